// File: rtl/hsl_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Property macros used by the top-level RTL; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define HSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define HSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL converter package
// Field widths, ranges and fixed-point constants shared by the RTL.
// ----------------------------------------------------------------------------
package hsl_pkg;

	// Item field widths
	localparam int HUE_W = 9;
	localparam int SAT_W = 7;
	localparam int LIT_W = 7;
	localparam int CH_W  = 8;

	// Valid input ranges
	localparam int HUE_MAX = 360;
	localparam int PCT_MAX = 100;

	// p and d are fractions over 10000; x is a hue weight 0..60
	localparam int FRAC_W = 14;
	localparam int X_W    = 6;

	// Channel value v = 60*p + d*x, over 600000
	localparam int V_W = 20;

	// round(255*v/600000) = floor((17*v + 20000) / 40000)
	//                     = floor(((17*v + 20000) >> 6) / 625)
	localparam int SCALE_MUL  = 17;
	localparam int ROUND_BIAS = 20000;
	localparam int N_W        = 24;
	localparam int SCALE_SH   = 6;
	localparam int Y_W        = N_W - SCALE_SH;

	// Divide by 625 as multiply by ceil(2^28/625); exact for y < 2^18
	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = 19;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(429497);
	localparam int PROD_W   = Y_W + RECIP_W;

	// Per-stage advance enables for the channel datapath
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} hsl_adv_t;

endpackage

// File: rtl/hsl_if.sv
// ----------------------------------------------------------------------------
// HSL converter channel interfaces
// Valid/ready channels for HSL input items and RGB result items.
// ----------------------------------------------------------------------------

// HSL input channel
interface hsl_in_if;
	logic                       valid;
	logic                       ready;
	logic [hsl_pkg::HUE_W-1:0]  hue;
	logic [hsl_pkg::SAT_W-1:0]  saturation;
	logic [hsl_pkg::LIT_W-1:0]  lightness;

	modport source (output valid, hue, saturation, lightness, input ready);
	modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// RGB result channel
interface rgb_out_if;
	logic                      valid;
	logic                      ready;
	logic [hsl_pkg::CH_W-1:0]  red;
	logic [hsl_pkg::CH_W-1:0]  green;
	logic [hsl_pkg::CH_W-1:0]  blue;
	logic                      invalid;

	modport source (output valid, red, green, blue, invalid, input ready);
	modport sink   (input valid, red, green, blue, invalid, output ready);
endinterface

// File: rtl/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front stage
// Range check, low/high levels p and d = q - p, and per-channel hue weights.
// ----------------------------------------------------------------------------
module hsl_front (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hsl_pkg::HUE_W-1:0]  hue,
	input  logic [hsl_pkg::SAT_W-1:0]  saturation,
	input  logic [hsl_pkg::LIT_W-1:0]  lightness,
	output logic                       inv_s1,
	output logic [hsl_pkg::FRAC_W-1:0] p_s1,
	output logic [hsl_pkg::FRAC_W-1:0] d_s1,
	output logic [hsl_pkg::X_W-1:0]    xr_s1,
	output logic [hsl_pkg::X_W-1:0]    xg_s1,
	output logic [hsl_pkg::X_W-1:0]    xb_s1
);
	import hsl_pkg::*;

	localparam int W = 16;

	logic                inv;
	logic [W-1:0]        l_w;
	logic [W-1:0]        s_w;
	logic [W-1:0]        ls;
	logic [W-1:0]        q;
	logic [W-1:0]        p;
	logic [W-1:0]        d;
	logic [HUE_W:0]      h_w;
	logic [HUE_W:0]      deg_r;
	logic [HUE_W:0]      deg_b;

	// Weight of the rising/high/falling/low piece for an angle 0..360
	function automatic logic [X_W-1:0] hue_weight(input logic [HUE_W:0] deg);
		logic [X_W-1:0] x;
		if (deg < (HUE_W+1)'(60))
			x = X_W'(deg);
		else if (deg < (HUE_W+1)'(180))
			x = X_W'(60);
		else if (deg < (HUE_W+1)'(240))
			x = X_W'((HUE_W+1)'(240) - deg);
		else
			x = '0;
		return x;
	endfunction

	// Range check
	assign inv = (hue > HUE_W'(HUE_MAX)) || (saturation > SAT_W'(PCT_MAX))
		|| (lightness > LIT_W'(PCT_MAX));

	// q = l*(100+s) below half lightness, else 100*(l+s) - l*s; p = 200*l - q
	assign l_w = W'(lightness);
	assign s_w = W'(saturation);
	assign ls  = l_w * s_w;
	assign q   = (lightness < LIT_W'(50)) ? (W'(100) * l_w + ls)
		: (W'(100) * (l_w + s_w) - ls);
	assign p   = W'(200) * l_w - q;
	assign d   = q - p;

	// Channel angles: red h+120, green h, blue h-120, wrapped into 0..360
	assign h_w   = (HUE_W+1)'(hue);
	assign deg_r = (h_w + (HUE_W+1)'(120) > (HUE_W+1)'(HUE_MAX))
		? (h_w - (HUE_W+1)'(240)) : (h_w + (HUE_W+1)'(120));
	assign deg_b = (h_w < (HUE_W+1)'(120)) ? (h_w + (HUE_W+1)'(240))
		: (h_w - (HUE_W+1)'(120));

	// Stage 1 register; an invalid item carries zero levels, giving zero output
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= inv;
			p_s1   <= inv ? '0 : p[FRAC_W-1:0];
			d_s1   <= inv ? '0 : d[FRAC_W-1:0];
			xr_s1  <= hue_weight(deg_r);
			xg_s1  <= hue_weight(h_w);
			xb_s1  <= hue_weight(deg_b);
		end
	end

endmodule

// File: rtl/hsl_chan.sv
// ----------------------------------------------------------------------------
// HSL channel datapath
// Level blend, scale with rounding bias, and constant divide to 8 bits.
// ----------------------------------------------------------------------------
module hsl_chan (
	input  logic                       clk,
	input  hsl_pkg::hsl_adv_t          adv,
	input  logic [hsl_pkg::FRAC_W-1:0] p,
	input  logic [hsl_pkg::FRAC_W-1:0] d,
	input  logic [hsl_pkg::X_W-1:0]    x,
	output logic [hsl_pkg::CH_W-1:0]   ch_s4
);
	import hsl_pkg::*;

	logic [V_W-1:0]    v;
	logic [V_W-1:0]    v_s2;
	logic [N_W-1:0]    n;
	logic [Y_W-1:0]    y_s3;
	logic [PROD_W-1:0] prod;

	// v = 60*p + d*x, at most 600000
	assign v = V_W'(p) * V_W'(60) + V_W'(d) * V_W'(x);

	// n = 17*v + 20000, later divided by 40000
	assign n = N_W'(v_s2) * N_W'(SCALE_MUL) + N_W'(ROUND_BIAS);

	// y / 625 through the reciprocal
	assign prod = PROD_W'(y_s3) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (adv.s2)
			v_s2 <= v;
		if (adv.s3)
			y_s3 <= n[N_W-1:SCALE_SH];
		if (adv.s4)
			ch_s4 <= prod[RECIP_SH+CH_W-1:RECIP_SH];
	end

endmodule

// File: rtl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Four-stage pipeline turning HSL items into 8-bit RGB with an invalid flag.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries hue (degrees 0..360), saturation and lightness (percent
//   0..100). pix_out carries red, green, blue and invalid; invalid is set
//   and the channels are zero when any input is above its range.
//   Both channels use valid/ready; an item moves when both are high.
//   An accepted item is registered in stage 1, then in stages 2, 3 and 4,
//   and pix_out presents it from stage 4. Throughput: one item per cycle
//   unless pix_out stalls; each of the four stages holds one item.
//   Stages: range check and levels, channel blend, scale, reciprocal divide.
//   Stall: when pix_out.ready is low the last stage holds its item; earlier
//   stages keep filling any empty slots, and pix_in.ready drops only when
//   every stage is occupied. Nothing is dropped or repeated.
//   Reset: arst_n clears all stage valid bits at once; no other state.
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter (
	input  logic     clk,
	input  logic     arst_n,
	hsl_in_if.sink   pix_in,
	rgb_out_if.source pix_out
);
	import hsl_pkg::*;

	logic              en1;
	hsl_adv_t          adv;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;
	logic              inv_s1;
	logic              inv_s2;
	logic              inv_s3;
	logic              inv_s4;
	logic [FRAC_W-1:0] p_s1;
	logic [FRAC_W-1:0] d_s1;
	logic [X_W-1:0]    xr_s1;
	logic [X_W-1:0]    xg_s1;
	logic [X_W-1:0]    xb_s1;

	// A stage advances when it is empty or the next stage advances
	assign adv.s4 = !v_s4 || pix_out.ready;
	assign adv.s3 = !v_s3 || adv.s4;
	assign adv.s2 = !v_s2 || adv.s3;
	assign en1    = !v_s1 || adv.s2;

	assign pix_in.ready = en1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= pix_in.valid;
			if (adv.s2)
				v_s2 <= v_s1;
			if (adv.s3)
				v_s3 <= v_s2;
			if (adv.s4)
				v_s4 <= v_s3;
		end
	end

	// Invalid flag travels with the item
	always_ff @(posedge clk) begin
		if (adv.s2)
			inv_s2 <= inv_s1;
		if (adv.s3)
			inv_s3 <= inv_s2;
		if (adv.s4)
			inv_s4 <= inv_s3;
	end

	hsl_front u_front (
		.clk        (clk),
		.en         (en1),
		.hue        (pix_in.hue),
		.saturation (pix_in.saturation),
		.lightness  (pix_in.lightness),
		.inv_s1     (inv_s1),
		.p_s1       (p_s1),
		.d_s1       (d_s1),
		.xr_s1      (xr_s1),
		.xg_s1      (xg_s1),
		.xb_s1      (xb_s1)
	);

	hsl_chan u_red (
		.clk   (clk),
		.adv   (adv),
		.p     (p_s1),
		.d     (d_s1),
		.x     (xr_s1),
		.ch_s4 (pix_out.red)
	);

	hsl_chan u_green (
		.clk   (clk),
		.adv   (adv),
		.p     (p_s1),
		.d     (d_s1),
		.x     (xg_s1),
		.ch_s4 (pix_out.green)
	);

	hsl_chan u_blue (
		.clk   (clk),
		.adv   (adv),
		.p     (p_s1),
		.d     (d_s1),
		.x     (xb_s1),
		.ch_s4 (pix_out.blue)
	);

	assign pix_out.valid   = v_s4;
	assign pix_out.invalid = inv_s4;

	// Invalid results carry zero channels
	`HSL_ASSERT_IMPL(a_inv_zero, clk, arst_n, pix_out.valid && pix_out.invalid, pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0)

	// Input is refused only when every stage is full and the output stalls
	`HSL_ASSERT_IMPL(a_full_stall, clk, arst_n, !pix_in.ready, v_s1 && v_s2 && v_s3 && v_s4 && !pix_out.ready)

	// With the output open, the third stage's item is presented next cycle
	`HSL_ASSERT_NEXT(a_drain, clk, arst_n, v_s3 && pix_out.ready, pix_out.valid)

	// An out-of-range hue is flagged in stage 1
	`HSL_ASSERT_NEXT(a_inv_flag, clk, arst_n, pix_in.valid && pix_in.ready && pix_in.hue > HUE_W'(HUE_MAX), v_s1 && inv_s1)

endmodule
